### hw/rtl/aiou_pkg.sv
// ----------------------------------------------------------------------------
// aiou_pkg: shared types for the 3D box IoU core
// Holds the per-item control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package aiou_pkg;

  // number of spatial axes
  localparam int AXES = 3;

  // control word that rides along with each item
  typedef struct packed {
    logic vld;    // item present in this stage
    logic touch;  // both boxes valid and in contact
    logic va;     // box A valid
    logic vb;     // box B valid
    logic ok;     // touch and nonzero union: quotient is meaningful
  } ctl_t;

endpackage

### hw/rtl/aiou_vol.sv
// ----------------------------------------------------------------------------
// aiou_vol: three-stage volume multiplier
// Forms sx*sy*sz exactly, with no product wider than 2*COORD_BITS bits.
// ----------------------------------------------------------------------------
module aiou_vol #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic [COORD_BITS-1:0]   sx,
  input  logic [COORD_BITS-1:0]   sy,
  input  logic [COORD_BITS-1:0]   sz,
  output logic [3*COORD_BITS-1:0] vol
);
  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C;
  localparam int VW = 3 * C;

  logic [PW-1:0] pxy_r, pxy_nxt;
  logic [C-1:0]  sz_r;
  logic [PW-1:0] plo_r, plo_nxt;
  logic [PW-1:0] phi_r, phi_nxt;
  logic [VW-1:0] vol_r, vol_nxt;

  // form the partial products and the final sum
  always_comb begin
    pxy_nxt = PW'(sx) * PW'(sy);
    plo_nxt = PW'(pxy_r[C-1:0]) * PW'(sz_r);
    phi_nxt = PW'(pxy_r[PW-1:C]) * PW'(sz_r);
    vol_nxt = VW'(plo_r) + {phi_r, {C{1'b0}}};
  end

  // advance the multiplier stages
  always_ff @(posedge clk) begin
    pxy_r <= pxy_nxt;
    sz_r  <= sz;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    vol_r <= vol_nxt;
  end

  assign vol = vol_r;

endmodule

### hw/rtl/aiou_div_cell.sv
// ----------------------------------------------------------------------------
// aiou_div_cell: one restoring division cell
// Resolves one quotient bit per item and hands the shifted remainder on.
// ----------------------------------------------------------------------------
module aiou_div_cell #(
  parameter int UW = 49,
  parameter int RW = 50,
  parameter int QW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  aiou_pkg::ctl_t  ctl_i,
  input  logic [UW-1:0]   u_i,
  input  logic [RW-1:0]   rem_i,
  input  logic [QW-1:0]   q_i,
  output aiou_pkg::ctl_t  ctl_o,
  output logic [UW-1:0]   u_o,
  output logic [RW-1:0]   rem_o,
  output logic [QW-1:0]   q_o
);
  import aiou_pkg::*;

  ctl_t          ctl_r;
  logic [UW-1:0] u_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          ge;
  logic [RW-1:0] diff;
  logic [UW-1:0] d;

  // compare, subtract when the divisor fits, shift for the next bit
  always_comb begin
    ge      = rem_i >= {1'b0, u_i};
    diff    = rem_i - {1'b0, u_i};
    d       = ge ? diff[UW-1:0] : rem_i[UW-1:0];
    rem_nxt = {d, 1'b0};
    q_nxt   = {q_i[QW-2:0], ge};
  end

  // hold control under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    u_r   <= u_i;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign ctl_o = ctl_r;
  assign u_o   = u_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

### hw/rtl/aabb_iou_3d_core.sv
// Path: an accepted item passes the side-length registers, the volume stages,
//   the union stages, the division cells and the output register in order.
// Throughput: one item per cycle; busy stays low, since every stage and every
//   division cell advances each cycle and the receiver cannot stall.
// Reset: synchronous active-low rst_n clears all stage valid bits; no results
//   are in flight afterwards.
// ----------------------------------------------------------------------------
// aabb_iou_3d_core: axis-aligned 3D box intersection over union
// Side lengths, exact volumes and union feed a row of division cells that
// resolve one quotient bit each, giving floor(inter*2^F/union).
// ----------------------------------------------------------------------------
module aabb_iou_3d_core #(
  parameter int COORD_BITS    = 16,
  parameter int IOU_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_min_x,
  input  logic signed [COORD_BITS-1:0] in_a_min_y,
  input  logic signed [COORD_BITS-1:0] in_a_min_z,
  input  logic signed [COORD_BITS-1:0] in_a_max_x,
  input  logic signed [COORD_BITS-1:0] in_a_max_y,
  input  logic signed [COORD_BITS-1:0] in_a_max_z,
  input  logic signed [COORD_BITS-1:0] in_b_min_x,
  input  logic signed [COORD_BITS-1:0] in_b_min_y,
  input  logic signed [COORD_BITS-1:0] in_b_min_z,
  input  logic signed [COORD_BITS-1:0] in_b_max_x,
  input  logic signed [COORD_BITS-1:0] in_b_max_y,
  input  logic signed [COORD_BITS-1:0] in_b_max_z,
  output logic                         out_valid,
  output logic [IOU_FRAC_BITS:0]       out_iou,
  output logic                         out_boxes_touch,
  output logic                         out_first_valid,
  output logic                         out_second_valid
);
  import aiou_pkg::*;

  localparam int C       = COORD_BITS;
  localparam int VW      = 3 * C;
  localparam int UW      = VW + 1;
  localparam int RW      = VW + 2;
  localparam int QW      = IOU_FRAC_BITS + 1;
  localparam int NCELL   = QW;
  localparam int VOL_LAT = 3;

  // ---------------- stage 1: validity, contact, side lengths ----------------
  logic signed [C-1:0] amn [AXES];
  logic signed [C-1:0] amx [AXES];
  logic signed [C-1:0] bmn [AXES];
  logic signed [C-1:0] bmx [AXES];
  logic signed [C-1:0] imn [AXES];
  logic signed [C-1:0] imx [AXES];
  logic signed [C:0]   da  [AXES];
  logic signed [C:0]   db  [AXES];
  logic signed [C:0]   di  [AXES];
  logic                va, vb, touch;

  logic [C-1:0] side_a_r [AXES];
  logic [C-1:0] side_b_r [AXES];
  logic [C-1:0] side_i_r [AXES];
  ctl_t         ctl1_r, ctl1_nxt;

  assign busy = 1'b0;

  // gather the corners by axis
  always_comb begin
    amn[0] = in_a_min_x; amn[1] = in_a_min_y; amn[2] = in_a_min_z;
    amx[0] = in_a_max_x; amx[1] = in_a_max_y; amx[2] = in_a_max_z;
    bmn[0] = in_b_min_x; bmn[1] = in_b_min_y; bmn[2] = in_b_min_z;
    bmx[0] = in_b_max_x; bmx[1] = in_b_max_y; bmx[2] = in_b_max_z;
  end

  // check validity and contact, take the intersection extents
  always_comb begin
    va    = 1'b1;
    vb    = 1'b1;
    touch = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (amn[i] > amx[i]) va = 1'b0;
      if (bmn[i] > bmx[i]) vb = 1'b0;
      if (!(amn[i] <= bmx[i] && bmn[i] <= amx[i])) touch = 1'b0;
      imn[i] = (amn[i] > bmn[i]) ? amn[i] : bmn[i];
      imx[i] = (amx[i] < bmx[i]) ? amx[i] : bmx[i];
      da[i]  = {amx[i][C-1], amx[i]} - {amn[i][C-1], amn[i]};
      db[i]  = {bmx[i][C-1], bmx[i]} - {bmn[i][C-1], bmn[i]};
      di[i]  = {imx[i][C-1], imx[i]} - {imn[i][C-1], imn[i]};
    end
    touch          = touch & va & vb;
    ctl1_nxt.vld   = start;
    ctl1_nxt.touch = touch;
    ctl1_nxt.va    = va;
    ctl1_nxt.vb    = vb;
    ctl1_nxt.ok    = 1'b0;
  end

  // register the side lengths; only valid boxes use them
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      side_a_r[i] <= da[i][C-1:0];
      side_b_r[i] <= db[i][C-1:0];
      side_i_r[i] <= di[i][C-1:0];
    end
  end

  // ---------------- stages 2-4: volumes ----------------
  logic [VW-1:0] vol_a, vol_b, vol_i;
  ctl_t          ctl_vol_r [VOL_LAT];

  aiou_vol #(.COORD_BITS(C)) u_vol_a (
    .clk (clk),
    .sx  (side_a_r[0]),
    .sy  (side_a_r[1]),
    .sz  (side_a_r[2]),
    .vol (vol_a)
  );

  aiou_vol #(.COORD_BITS(C)) u_vol_b (
    .clk (clk),
    .sx  (side_b_r[0]),
    .sy  (side_b_r[1]),
    .sz  (side_b_r[2]),
    .vol (vol_b)
  );

  aiou_vol #(.COORD_BITS(C)) u_vol_i (
    .clk (clk),
    .sx  (side_i_r[0]),
    .sy  (side_i_r[1]),
    .sz  (side_i_r[2]),
    .vol (vol_i)
  );

  // ---------------- stages 5-6: union ----------------
  logic [UW-1:0] sum_r, sum_nxt;
  logic [VW-1:0] vi5_r, vi6_r;
  logic [UW-1:0] u_r, u_nxt;
  ctl_t          ctl5_r, ctl6_r, ctl6_nxt;

  always_comb begin
    sum_nxt     = {1'b0, vol_a} + {1'b0, vol_b};
    u_nxt       = sum_r - {1'b0, vi5_r};
    ctl6_nxt    = ctl5_r;
    ctl6_nxt.ok = ctl5_r.touch & (sum_r != {1'b0, vi5_r});
  end

  // advance control through stage 1 and the volume and union stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      for (int k = 0; k < VOL_LAT; k++) ctl_vol_r[k] <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else begin
      ctl1_r       <= ctl1_nxt;
      ctl_vol_r[0] <= ctl1_r;
      for (int k = 1; k < VOL_LAT; k++) ctl_vol_r[k] <= ctl_vol_r[k-1];
      ctl5_r <= ctl_vol_r[VOL_LAT-1];
      ctl6_r <= ctl6_nxt;
    end
  end

  // hold the union operands
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    vi5_r <= vol_i;
    u_r   <= u_nxt;
    vi6_r <= vi5_r;
  end

  // ---------------- division cell row ----------------
  ctl_t          c_ctl [NCELL+1];
  logic [QW-1:0] c_q   [NCELL+1];
  logic [UW-1:0] c_u   [NCELL];
  logic [RW-1:0] c_rem [NCELL];

  assign c_ctl[0] = ctl6_r;
  assign c_q[0]   = '0;
  assign c_u[0]   = u_r;
  assign c_rem[0] = RW'(vi6_r);

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k < NCELL - 1) begin : g_mid
      aiou_div_cell #(.UW(UW), .RW(RW), .QW(QW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (c_ctl[k]),
        .u_i   (c_u[k]),
        .rem_i (c_rem[k]),
        .q_i   (c_q[k]),
        .ctl_o (c_ctl[k+1]),
        .u_o   (c_u[k+1]),
        .rem_o (c_rem[k+1]),
        .q_o   (c_q[k+1])
      );
    end else begin : g_last
      aiou_div_cell #(.UW(UW), .RW(RW), .QW(QW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (c_ctl[k]),
        .u_i   (c_u[k]),
        .rem_i (c_rem[k]),
        .q_i   (c_q[k]),
        .ctl_o (c_ctl[k+1]),
        .u_o   (),
        .rem_o (),
        .q_o   (c_q[k+1])
      );
    end
  end

  // ---------------- output register ----------------
  logic          out_valid_r;
  logic [QW-1:0] iou_r, iou_nxt;
  logic          touch_r, va_r, vb_r;
  ctl_t          ctl_end;

  assign ctl_end = c_ctl[NCELL];

  // drop the quotient when there is no overlap or no union
  always_comb begin
    iou_nxt = ctl_end.ok ? c_q[NCELL] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    iou_r   <= iou_nxt;
    touch_r <= ctl_end.touch;
    va_r    <= ctl_end.va;
    vb_r    <= ctl_end.vb;
  end

  assign out_valid        = out_valid_r;
  assign out_iou          = iou_r;
  assign out_boxes_touch  = touch_r;
  assign out_first_valid  = va_r;
  assign out_second_valid = vb_r;

endmodule

### verif/aabb_iou_3d_check.sv
// ----------------------------------------------------------------------------
// aabb_iou_3d_check: result predictor and comparator for the 3D box IoU core
// Watches the item and result channels, computes the expected IoU and flags
// for every accepted box pair, and compares each strobed result in order.
// ----------------------------------------------------------------------------
module aabb_iou_3d_check #(
  parameter int COORD_BITS    = 16,
  parameter int IOU_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_min_x,
  input  logic signed [COORD_BITS-1:0] in_a_min_y,
  input  logic signed [COORD_BITS-1:0] in_a_min_z,
  input  logic signed [COORD_BITS-1:0] in_a_max_x,
  input  logic signed [COORD_BITS-1:0] in_a_max_y,
  input  logic signed [COORD_BITS-1:0] in_a_max_z,
  input  logic signed [COORD_BITS-1:0] in_b_min_x,
  input  logic signed [COORD_BITS-1:0] in_b_min_y,
  input  logic signed [COORD_BITS-1:0] in_b_min_z,
  input  logic signed [COORD_BITS-1:0] in_b_max_x,
  input  logic signed [COORD_BITS-1:0] in_b_max_y,
  input  logic signed [COORD_BITS-1:0] in_b_max_z,
  input  logic                         out_valid,
  input  logic [IOU_FRAC_BITS:0]       out_iou,
  input  logic                         out_boxes_touch,
  input  logic                         out_first_valid,
  input  logic                         out_second_valid,
  output int                           fail_cnt,
  output int                           pending_cnt
);
  import aiou_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [IOU_FRAC_BITS:0] iou;
    logic                   boxes_touch;
    logic                   first_valid;
    logic                   second_valid;
  } iou_res_t;

  iou_res_t pending_iou_q[$];
  int       mismatch_cnt = 0;

  // Exact volumes in 128 bits, then a truncating divide of inter*2^F by union
  function automatic iou_res_t predict_iou(input coord_t a_lo[AXES], input coord_t a_hi[AXES],
                                           input coord_t b_lo[AXES], input coord_t b_hi[AXES]);
    iou_res_t     r;
    logic [127:0] vol_a;
    logic [127:0] vol_b;
    logic [127:0] vol_i;
    logic [127:0] vol_u;
    coord_t       lo_i;
    coord_t       hi_i;
    r = '0;
    r.first_valid  = 1'b1;
    r.second_valid = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (a_lo[i] > a_hi[i]) r.first_valid = 1'b0;
      if (b_lo[i] > b_hi[i]) r.second_valid = 1'b0;
    end
    r.boxes_touch = r.first_valid & r.second_valid;
    // closed extents must meet on every axis
    for (int i = 0; i < AXES; i++) begin
      if (a_lo[i] > b_hi[i] || b_lo[i] > a_hi[i]) r.boxes_touch = 1'b0;
    end
    if (r.boxes_touch) begin
      vol_a = 128'd1;
      vol_b = 128'd1;
      vol_i = 128'd1;
      for (int i = 0; i < AXES; i++) begin
        lo_i  = (a_lo[i] > b_lo[i]) ? a_lo[i] : b_lo[i];
        hi_i  = (a_hi[i] < b_hi[i]) ? a_hi[i] : b_hi[i];
        vol_a = vol_a * 128'(longint'(a_hi[i]) - longint'(a_lo[i]));
        vol_b = vol_b * 128'(longint'(b_hi[i]) - longint'(b_lo[i]));
        vol_i = vol_i * 128'(longint'(hi_i) - longint'(lo_i));
      end
      vol_u = vol_a + vol_b - vol_i;
      // flat boxes give a zero union; keep iou at zero then
      if (vol_u != 128'd0) begin
        r.iou = (IOU_FRAC_BITS + 1)'((vol_i << IOU_FRAC_BITS) / vol_u);
      end
    end
    return r;
  endfunction

  // Predict on acceptance, compare on strobe
  always @(posedge clk) begin : watch
    coord_t   a_lo[AXES];
    coord_t   a_hi[AXES];
    coord_t   b_lo[AXES];
    coord_t   b_hi[AXES];
    iou_res_t want;
    iou_res_t got;
    if (rst_n && start && !busy) begin
      a_lo[0] = in_a_min_x; a_lo[1] = in_a_min_y; a_lo[2] = in_a_min_z;
      a_hi[0] = in_a_max_x; a_hi[1] = in_a_max_y; a_hi[2] = in_a_max_z;
      b_lo[0] = in_b_min_x; b_lo[1] = in_b_min_y; b_lo[2] = in_b_min_z;
      b_hi[0] = in_b_max_x; b_hi[1] = in_b_max_y; b_hi[2] = in_b_max_z;
      pending_iou_q.push_back(predict_iou(a_lo, a_hi, b_lo, b_hi));
    end
    if (rst_n && out_valid) begin
      got = {out_iou, out_boxes_touch, out_first_valid, out_second_valid};
      if (pending_iou_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: iou=%0d touch=%0b va=%0b vb=%0b",
                   got.iou, got.boxes_touch, got.first_valid, got.second_valid);
        mismatch_cnt++;
      end else begin
        want = pending_iou_q.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch: exp iou=%0d touch=%0b va=%0b vb=%0b",
                     want.iou, want.boxes_touch, want.first_valid, want.second_valid);
            $display("          got iou=%0d touch=%0b va=%0b vb=%0b",
                     got.iou, got.boxes_touch, got.first_valid, got.second_valid);
          end
          mismatch_cnt++;
        end
      end
    end
    pending_cnt <= pending_iou_q.size();
    fail_cnt    <= mismatch_cnt;
  end

endmodule

### verif/tb_aabb_iou_3d_core.sv
// ----------------------------------------------------------------------------
// tb_aabb_iou_3d_core: stimulus and verdict for the 3D box IoU core
// Sends directed box pairs (extremes, invalid, apart, touching, flat, nested)
// and then random pairs over phases of sender idling; the checker beside the
// core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aabb_iou_3d_core;
  import aiou_pkg::AXES;

  localparam int COORD_BITS    = 16;
  localparam int IOU_FRAC_BITS = 16;
  localparam int LATENCY       = IOU_FRAC_BITS + 7;
  localparam int PHASE_ITEMS   = 312;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int CMAX          = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN          = -(1 << (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_a_min_x = '0, in_a_min_y = '0, in_a_min_z = '0;
  coord_t in_a_max_x = '0, in_a_max_y = '0, in_a_max_z = '0;
  coord_t in_b_min_x = '0, in_b_min_y = '0, in_b_min_z = '0;
  coord_t in_b_max_x = '0, in_b_max_y = '0, in_b_max_z = '0;
  logic                   out_valid;
  logic [IOU_FRAC_BITS:0] out_iou;
  logic                   out_boxes_touch;
  logic                   out_first_valid;
  logic                   out_second_valid;
  int                     fail_cnt;
  int                     pending_cnt;
  int                     cycle_cnt = 0;

  // staging corners of the next box pair
  coord_t a_lo[AXES], a_hi[AXES], b_lo[AXES], b_hi[AXES];

  aabb_iou_3d_core #(
    .COORD_BITS   (COORD_BITS),
    .IOU_FRAC_BITS(IOU_FRAC_BITS)
  ) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_min_x(in_a_min_x), .in_a_min_y(in_a_min_y), .in_a_min_z(in_a_min_z),
    .in_a_max_x(in_a_max_x), .in_a_max_y(in_a_max_y), .in_a_max_z(in_a_max_z),
    .in_b_min_x(in_b_min_x), .in_b_min_y(in_b_min_y), .in_b_min_z(in_b_min_z),
    .in_b_max_x(in_b_max_x), .in_b_max_y(in_b_max_y), .in_b_max_z(in_b_max_z),
    .out_valid(out_valid), .out_iou(out_iou), .out_boxes_touch(out_boxes_touch),
    .out_first_valid(out_first_valid), .out_second_valid(out_second_valid)
  );

  aabb_iou_3d_check #(
    .COORD_BITS   (COORD_BITS),
    .IOU_FRAC_BITS(IOU_FRAC_BITS)
  ) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_min_x(in_a_min_x), .in_a_min_y(in_a_min_y), .in_a_min_z(in_a_min_z),
    .in_a_max_x(in_a_max_x), .in_a_max_y(in_a_max_y), .in_a_max_z(in_a_max_z),
    .in_b_min_x(in_b_min_x), .in_b_min_y(in_b_min_y), .in_b_min_z(in_b_min_z),
    .in_b_max_x(in_b_max_x), .in_b_max_y(in_b_max_y), .in_b_max_z(in_b_max_z),
    .out_valid(out_valid), .out_iou(out_iou), .out_boxes_touch(out_boxes_touch),
    .out_first_valid(out_first_valid), .out_second_valid(out_second_valid),
    .fail_cnt(fail_cnt), .pending_cnt(pending_cnt)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic coord_t clamp_coord(input int v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(CMAX - CMIN)) + CMIN;
  endfunction

  task automatic set_box_a(input int x0, input int y0, input int z0,
                           input int x1, input int y1, input int z1);
    a_lo[0] = coord_t'(x0); a_lo[1] = coord_t'(y0); a_lo[2] = coord_t'(z0);
    a_hi[0] = coord_t'(x1); a_hi[1] = coord_t'(y1); a_hi[2] = coord_t'(z1);
  endtask

  task automatic set_box_b(input int x0, input int y0, input int z0,
                           input int x1, input int y1, input int z1);
    b_lo[0] = coord_t'(x0); b_lo[1] = coord_t'(y0); b_lo[2] = coord_t'(z0);
    b_hi[0] = coord_t'(x1); b_hi[1] = coord_t'(y1); b_hi[2] = coord_t'(z1);
  endtask

  // Present the staged pair and hold it until the core takes it
  task automatic drive_pair();
    start      <= 1'b1;
    in_a_min_x <= a_lo[0]; in_a_min_y <= a_lo[1]; in_a_min_z <= a_lo[2];
    in_a_max_x <= a_hi[0]; in_a_max_y <= a_hi[1]; in_a_max_z <= a_hi[2];
    in_b_min_x <= b_lo[0]; in_b_min_y <= b_lo[1]; in_b_min_z <= b_lo[2];
    in_b_max_x <= b_hi[0]; in_b_max_y <= b_hi[1]; in_b_max_z <= b_hi[2];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Build a random pair: mostly overlapping boxes, some touching, invalid or raw noise
  task automatic gen_pair();
    int kind;
    int max_side;
    int side;
    int k;
    coord_t tmp;
    kind = int'($urandom_range(99));
    if (kind < 15) begin
      for (int i = 0; i < AXES; i++) begin
        a_lo[i] = coord_t'($urandom); a_hi[i] = coord_t'($urandom);
        b_lo[i] = coord_t'($urandom); b_hi[i] = coord_t'($urandom);
      end
      return;
    end
    max_side = (kind < 25) ? 16 : (1 << $urandom_range(16)) - 1;
    for (int i = 0; i < AXES; i++) begin
      a_lo[i] = coord_t'(rand_coord());
      a_hi[i] = clamp_coord(int'(a_lo[i]) + int'($urandom_range(max_side)));
      side    = int'(a_hi[i]) - int'(a_lo[i]);
      if ($urandom_range(19) == 0) begin
        // same extent as box A on this axis
        b_lo[i] = a_lo[i];
        b_hi[i] = a_hi[i];
      end else begin
        b_lo[i] = clamp_coord(int'(a_lo[i]) + int'($urandom_range(2 * side + 8)) - side - 4);
        b_hi[i] = clamp_coord(int'(b_lo[i]) + int'($urandom_range(2 * side + 4)));
      end
    end
    if (kind < 35) begin
      // snap B against A on one axis so the pair only touches there
      k    = int'($urandom_range(AXES - 1));
      side = int'(a_hi[k]) - int'(a_lo[k]);
      if ($urandom_range(1)) begin
        b_lo[k] = a_hi[k];
        b_hi[k] = clamp_coord(int'(a_hi[k]) + int'($urandom_range(side + 2)));
      end else begin
        b_hi[k] = a_lo[k];
        b_lo[k] = clamp_coord(int'(a_lo[k]) - int'($urandom_range(side + 2)));
      end
    end else if (kind < 42) begin
      // invert one axis of one box
      k = int'($urandom_range(AXES - 1));
      if ($urandom_range(1)) begin
        if (a_lo[k] == a_hi[k]) a_hi[k] = (a_lo[k] == coord_t'(CMIN)) ? coord_t'(CMAX) : coord_t'(CMIN);
        tmp = a_lo[k]; a_lo[k] = a_hi[k]; a_hi[k] = tmp;
      end else begin
        if (b_lo[k] == b_hi[k]) b_hi[k] = (b_lo[k] == coord_t'(CMIN)) ? coord_t'(CMAX) : coord_t'(CMIN);
        tmp = b_lo[k]; b_lo[k] = b_hi[k]; b_hi[k] = tmp;
      end
    end
  endtask

  // Directed pairs, then random phases of sender idling, then drain and verdict
  initial begin : stimulus
    int idle_pct[4];
    idle_pct = '{0, 70, 0, 33};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // identical boxes with volume
    set_box_a(0, 0, 0, 9, 9, 9);                   set_box_b(0, 0, 0, 9, 9, 9);       drive_pair();
    set_box_a(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX); set_box_b(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    drive_pair();
    // tiny box inside the full range
    set_box_b(0, 0, 0, 1, 1, 1);                   drive_pair();
    // nearly identical full-range boxes: truncation just under one
    set_box_b(CMIN + 1, CMIN, CMIN, CMAX, CMAX, CMAX); drive_pair();
    // invalid A, invalid B, both invalid
    set_box_a(5, 0, 0, 1, 4, 4);                   set_box_b(0, 0, 0, 4, 4, 4);       drive_pair();
    set_box_a(0, 0, 0, 4, 4, 4);                   set_box_b(0, 0, 3, 4, 4, 2);       drive_pair();
    set_box_a(0, 7, 0, 4, 6, 4);                   set_box_b(0, CMAX, 0, 4, CMIN, 4); drive_pair();
    // apart on x, y, z
    set_box_a(0, 0, 0, 10, 10, 10);                set_box_b(11, 0, 0, 20, 10, 10);   drive_pair();
    set_box_b(0, 11, 0, 10, 20, 10);               drive_pair();
    set_box_b(0, 0, -20, 10, 10, -1);              drive_pair();
    // touching on a face, an edge and a corner
    set_box_b(10, 0, 0, 20, 10, 10);               drive_pair();
    set_box_b(10, 10, 0, 20, 20, 10);              drive_pair();
    set_box_b(-5, -5, -5, 0, 0, 0);                drive_pair();
    // flat boxes with a zero union
    set_box_a(0, 0, 0, 0, 5, 5);                   set_box_b(0, 0, 0, 0, 5, 5);       drive_pair();
    set_box_a(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN); set_box_b(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    drive_pair();
    // flat box inside a solid one
    set_box_a(2, 0, 0, 2, 5, 5);                   set_box_b(0, 0, 0, 5, 5, 5);       drive_pair();
    // partial overlap and nesting
    set_box_a(0, 0, 0, 4, 4, 4);                   set_box_b(2, 2, 2, 6, 6, 6);       drive_pair();
    set_box_a(1, 1, 1, 3, 3, 3);                   set_box_b(-7, -7, -7, 9, 9, 9);    drive_pair();
    // opposite halves of the range, apart by one
    set_box_a(CMIN, CMIN, CMIN, -1, -1, -1);       set_box_b(0, 0, 0, CMAX, CMAX, CMAX);
    drive_pair();
    // point at the top corner of the full range
    set_box_a(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX); set_box_b(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    drive_pair();
    // across the sign boundary
    set_box_a(-1, -1, -1, 0, 0, 0);                set_box_b(0, -1, -1, 1, 0, 0);     drive_pair();
    set_box_a(-1, -1, -1, 1, 1, 1);                set_box_b(0, 0, 0, 1, 1, 1);       drive_pair();

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (int'($urandom_range(99)) < idle_pct[p]) begin
          start <= 1'b0;
          @(posedge clk);
        end
        gen_pair();
        drive_pair();
      end
    end
    start <= 1'b0;

    // drain, then give stray results time to show up
    while (pending_cnt != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
